// ===== design/bfsum_pkg.sv =====
// shared types, constants and float helpers for the bf16 four-way sum
package bfsum_pkg;

  localparam int unsigned NumOps = 4;
  localparam int unsigned NumAdds = NumOps - 1;

  localparam logic [31:0] ExpMask = 32'h7f80_0000;
  localparam logic [31:0] ManMask = 32'h007f_ffff;
  localparam logic [31:0] QuietBit = 32'h0040_0000;
  localparam logic [31:0] DefNegNan = 32'hffc0_0000;
  localparam logic [15:0] CanonNan = 16'h7fc0;

  typedef logic [15:0] bf16_t;
  typedef logic [31:0] fp32_t;

  // payload carried on the input channel
  typedef struct packed {
    bf16_t value_0;
    bf16_t value_1;
    bf16_t value_2;
    bf16_t value_3;
  } bfsum_in_t;

  typedef struct packed {
    bf16_t sum_bf16;
  } bfsum_out_t;

  // per-stage control handed down the chain
  typedef struct packed {
    logic valid;
    logic per_add_rnd;
  } bfsum_ctl_t;

  function automatic fp32_t widen(input bf16_t h);
    return {h, 16'h0000};
  endfunction

  // rne narrowing, nan canonicalized with sign kept
  function automatic bf16_t narrow(input fp32_t u);
    logic [32:0] s;
    if ((u & ExpMask) == ExpMask) begin
      if ((u & ManMask) != 32'd0) return {u[31], CanonNan[14:0]};
      return u[31:16];
    end
    s = {1'b0, u} + 33'h0_7fff + {32'd0, u[16]};
    return s[31:16];
  endfunction

  // count leading zeros of a 28-bit value
  function automatic logic [4:0] clz28(input logic [27:0] v);
    logic [4:0] n;
    logic found;
    n = 5'd28;
    found = 1'b0;
    for (int i = 27; i >= 0; i--) begin
      if (!found && v[i]) begin
        n = 5'(27 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  // binary32 add, round to nearest even, subnormals kept
  function automatic fp32_t add32(input fp32_t x, input fp32_t y);
    logic        xn, yn, xi, yi;
    logic [7:0]  ex, ey, eb, es;
    logic [23:0] mx, my, mb, ms;
    logic        sb, ss;
    logic [7:0]  d;
    logic [26:0] ab, as_, sh;
    logic        stk;
    logic [27:0] r;
    logic [4:0]  lz;
    logic [9:0]  e;
    logic [27:0] n;
    logic [24:0] m;
    logic        rb, st2;
    logic [8:0]  ef;
    xn = (x[30:23] == 8'hff) && (x[22:0] != 23'd0);
    yn = (y[30:23] == 8'hff) && (y[22:0] != 23'd0);
    xi = (x[30:0] == ExpMask[30:0]);
    yi = (y[30:0] == ExpMask[30:0]);
    if (xn) return x | QuietBit;
    if (yn) return y | QuietBit;
    if (xi && yi && (x[31] != y[31])) return DefNegNan;
    if (xi) return x;
    if (yi) return y;
    ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
    mx = {x[30:23] != 8'd0, x[22:0]};
    my = {y[30:23] != 8'd0, y[22:0]};
    if ({ex, mx} >= {ey, my}) begin
      eb = ex; mb = mx; sb = x[31]; es = ey; ms = my; ss = y[31];
    end else begin
      eb = ey; mb = my; sb = y[31]; es = ex; ms = mx; ss = x[31];
    end
    d = eb - es;
    ab = {mb, 3'b000};
    as_ = {ms, 3'b000};
    if (d > 8'd26) begin
      sh = 27'd0;
      stk = (ms != 24'd0);
    end else begin
      sh = as_ >> d;
      stk = ((sh << d) != as_);
    end
    sh[0] = sh[0] | stk;
    if (sb == ss) r = {1'b0, ab} + {1'b0, sh};
    else r = {1'b0, ab} - {1'b0, sh};
    if (r == 28'd0) return 32'd0 | {x[31] & y[31], 31'd0};
    lz = clz28(r);
    // align so the leading one sits at bit 26
    e = {2'b00, eb} + 10'd1 - {5'd0, lz};
    if ($signed(e) < 10'sd1) begin
      n = r << (lz - 5'd1 - (5'd1 - e[4:0]));
      e = 10'd0;
    end else begin
      n = (lz == 5'd0) ? ((r >> 1) | {27'd0, r[0]}) : (r << (lz - 5'd1));
    end
    m = {1'b0, n[26:3]};
    rb = n[2];
    st2 = n[1] | n[0];
    if (rb && (st2 || m[0])) m = m + 25'd1;
    if (e == 10'd0) begin
      ef = m[23] ? 9'd1 : 9'd0;
      return {sb, ef[7:0], m[22:0]};
    end
    ef = e[8:0];
    if (m[24]) begin
      ef = ef + 9'd1;
      m = m >> 1;
    end
    if (ef >= 9'd255) return {sb, 8'hff, 23'd0};
    return {sb, ef[7:0], m[22:0]};
  endfunction

endpackage

// ===== design/bfsum_if.sv =====
// valid/ready channel interfaces for the bf16 four-way sum
interface bfsum_in_if;
  import bfsum_pkg::*;
  logic      valid;
  logic      ready;
  bfsum_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bfsum_out_if;
  import bfsum_pkg::*;
  logic       valid;
  logic       ready;
  bfsum_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bfsum_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/bfsum_cell.sv =====
// one adder cell of the chain: adds its operand to the running sum
module bfsum_cell
  import bfsum_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       adv_i,
  input  bfsum_ctl_t ctl_i,
  input  fp32_t      acc_i,
  input  bf16_t      ops_i [NumOps],
  output bfsum_ctl_t ctl_o,
  output fp32_t      acc_o,
  output bf16_t      ops_o [NumOps],
  input  logic [1:0] idx_i
);

  bfsum_ctl_t ctl_q;
  fp32_t      acc_q, acc_d, raw;
  bf16_t      ops_q [NumOps];

  always_comb begin
    raw = add32(acc_i, widen(ops_i[idx_i]));
    acc_d = ctl_i.per_add_rnd ? widen(narrow(raw)) : raw;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (adv_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      acc_q <= acc_d;
      ops_q <= ops_i;
    end
  end

  assign ctl_o = ctl_q;
  assign acc_o = acc_q;
  assign ops_o = ops_q;

endmodule

// ===== design/bf16_four_way_sum.sv =====
// top level of the bf16 four-way sum: chain of three adder cells
//
// channel   dir   payload                       handshake
// in_ch     in    value_0..value_3 (bf16)       valid/ready
// out_ch    out   sum_bf16 (bf16)               valid/ready
// cfg_ch    in    per-add rounding flag (1 bit) valid/ready
//
// one item per cycle while the output is not stalled; one binary32 add per cell sets the cycle
// the result is registered by the three cells in turn and then by the output
// register, each capture taking place only when the chain advances
// the whole chain advances when the output register is free or being taken
// a stalled output holds the chain, so nothing is dropped
// reset clears valids and the per-add rounding flag
module bf16_four_way_sum
  import bfsum_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  bfsum_in_if.sink      in_ch,
  bfsum_out_if.source   out_ch,
  bfsum_cfg_if.sink     cfg_ch
);

  logic       round_q;
  logic       adv;
  bfsum_ctl_t ctl [NumAdds+1];
  fp32_t      acc [NumAdds+1];
  bf16_t      ops [NumAdds+1][NumOps];
  logic       out_valid_q;
  bf16_t      out_q;

  // config taken any time; the user must write it only while idle (not enforced)
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      round_q <= 1'b0;
    end else if (cfg_ch.valid) begin
      round_q <= cfg_ch.data;
    end
  end

  // chain moves when the output slot can take what comes out of the last cell
  assign adv = !out_valid_q || out_ch.ready;
  assign in_ch.ready = adv;

  // head of the chain: operand zero widened as the starting sum
  assign ctl[0].valid = in_ch.valid;
  assign ctl[0].per_add_rnd = round_q;
  assign acc[0] = widen(in_ch.data.value_0);
  assign ops[0][0] = in_ch.data.value_0;
  assign ops[0][1] = in_ch.data.value_1;
  assign ops[0][2] = in_ch.data.value_2;
  assign ops[0][3] = in_ch.data.value_3;

  for (genvar g = 0; g < NumAdds; g++) begin : g_cell
    bfsum_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .adv_i (adv),
      .ctl_i (ctl[g]),
      .acc_i (acc[g]),
      .ops_i (ops[g]),
      .ctl_o (ctl[g+1]),
      .acc_o (acc[g+1]),
      .ops_o (ops[g+1]),
      .idx_i (2'(g + 1))
    );
  end

  // output register with final rne narrowing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= ctl[NumAdds].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= narrow(acc[NumAdds]);
    end
  end

  assign out_ch.valid = out_valid_q;
  assign out_ch.data.sum_bf16 = out_q;

  // a stalled result must hold its value
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ch.ready |=> out_valid_q && $stable(out_q))
    else $error("result changed while stalled");

  // an accepted item reaches the output slot once the chain has advanced through every cell
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ch.valid && in_ch.ready ##1 adv ##1 adv ##1 adv |=> out_valid_q)
    else $error("item lost in chain");

  // no input taken while a full output is stalled
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken during stall");

endmodule

// ===== verif/tb_top.sv =====
// testbench for the bf16 four-way sum: random and corner items checked against a local predictor
`timescale 1ns / 1ps

module tb_top;
  import bfsum_pkg::*;

  // ordered-sum predictor and the queue of sums still owed by the block
  class sum_scoreboard;
    logic      per_add_rnd;
    bf16_t     pending_sums[$];
    int        mismatches;

    function new();
      per_add_rnd = 1'b0;
      mismatches = 0;
    endfunction

    // rne narrowing to bf16, nan canonicalized with its sign
    function bf16_t to_bf16(fp32_t u);
      logic [32:0] s;
      if (u[30:23] == 8'hff) begin
        if (u[22:0] != 23'd0) return {u[31], 15'h7fc0};
        return u[31:16];
      end
      s = {1'b0, u} + 33'h7fff + {32'd0, u[16]};
      return s[31:16];
    endfunction

    // exact binary32 add, rounded once to nearest even
    function fp32_t fp32_sum(fp32_t x, fp32_t y);
      int     ex, ey, eb, es, d, base, p, ee, sh;
      longint mx, my, mb, ms, va, vb, s, mag, q, rem, half;
      logic   sgb, sgs, sg;
      if (x[30:23] == 8'hff && x[22:0] != 23'd0) return x | 32'h0040_0000;
      if (y[30:23] == 8'hff && y[22:0] != 23'd0) return y | 32'h0040_0000;
      if (x[30:0] == 31'h7f80_0000 && y[30:0] == 31'h7f80_0000 && x[31] != y[31])
        return 32'hffc0_0000;
      if (x[30:0] == 31'h7f80_0000) return x;
      if (y[30:0] == 31'h7f80_0000) return y;
      ex = (x[30:23] == 8'd0) ? 1 : int'(x[30:23]);
      ey = (y[30:23] == 8'd0) ? 1 : int'(y[30:23]);
      mx = longint'({x[30:23] != 8'd0, x[22:0]});
      my = longint'({y[30:23] != 8'd0, y[22:0]});
      if (ex > ey || (ex == ey && mx >= my)) begin
        eb = ex; mb = mx; sgb = x[31]; es = ey; ms = my; sgs = y[31];
      end else begin
        eb = ey; mb = my; sgb = y[31]; es = ex; ms = mx; sgs = x[31];
      end
      d = eb - es;
      // far below the bigger operand the smaller one only acts as a sticky bit
      if (d > 30) begin
        va = mb << 30; vb = (ms != 0) ? 1 : 0; base = eb - 30;
      end else begin
        va = mb << d; vb = ms; base = es;
      end
      s = (sgb ? -va : va) + (sgs ? -vb : vb);
      if (s == 0) return {x[31] & y[31], 31'd0};
      sg = (s < 0);
      mag = sg ? -s : s;
      p = 0;
      for (int i = 62; i >= 0; i--) if (p == 0 && mag[i]) p = i;
      ee = base + p - 23;
      if (ee < 1) ee = 1;
      sh = ee - base;
      if (sh <= 0) begin
        q = mag << (-sh);
      end else begin
        q = mag >> sh;
        rem = mag & ((longint'(1) << sh) - 1);
        half = longint'(1) << (sh - 1);
        if (rem > half || (rem == half && q[0])) q = q + 1;
      end
      if (q >= (longint'(1) << 24)) begin
        q = q >> 1; ee = ee + 1;
      end
      if (ee >= 255) return {sg, 8'hff, 23'd0};
      return {sg, (q >= (longint'(1) << 23)) ? 8'(ee) : 8'd0, q[22:0]};
    endfunction

    function void note_item(bfsum_in_t it);
      fp32_t acc;
      bf16_t ops[4];
      ops = '{it.value_0, it.value_1, it.value_2, it.value_3};
      acc = {ops[0], 16'h0000};
      for (int k = 1; k < 4; k++) begin
        acc = fp32_sum(acc, {ops[k], 16'h0000});
        if (per_add_rnd) acc = {to_bf16(acc), 16'h0000};
      end
      pending_sums.push_back(to_bf16(acc));
    endfunction

    function void check_sum(bfsum_out_t res);
      bf16_t want;
      if (pending_sums.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected sum %h", res.sum_bf16);
        return;
      end
      want = pending_sums.pop_front();
      if (res.sum_bf16 !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("sum mismatch: expected %h got %h", want, res.sum_bf16);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  bfsum_in_if  in_ch ();
  bfsum_out_if out_ch ();
  bfsum_cfg_if cfg_ch ();

  bf16_four_way_sum u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  sum_scoreboard sb;
  logic          calm;      // last part of the run: no idling
  logic          hold_req;  // asks the receiver for a long hold-off

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // results are compared at the edge where they are taken
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) sb.check_sum(out_ch.data);
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (80) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // random operand, weighted toward the special encodings
  function automatic bf16_t pick_operand(bf16_t anchor);
    logic s;
    s = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 11))
      0: return {s, 15'h0000};
      1: return {s, 15'h7f80};
      2: return {s, 8'hff, 7'($urandom_range(1, 127))};
      3: return {s, 8'h00, 7'($urandom_range(1, 127))};
      4: return {s, 8'hfe, 7'($urandom)};
      5, 6: return {s, anchor[14:7], 7'($urandom)};  // near cancellation
      7: return {s, 8'(anchor[14:7] + $urandom_range(0, 9)), 7'($urandom)};
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_item(bfsum_in_t it);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_item(it);
  endtask

  // stop offering and wait for every owed sum, then let the pipe settle
  task automatic drain_sums();
    in_ch.valid <= 1'b0;
    while (sb.pending_sums.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_rnd_mode(logic v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk_i); while (!cfg_ch.ready);
    sb.per_add_rnd = v;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_random(int count);
    bfsum_in_t it;
    bf16_t     anchor;
    for (int n = 0; n < count; n++) begin
      anchor = 16'($urandom);
      it.value_0 = pick_operand(anchor);
      it.value_1 = pick_operand(anchor);
      it.value_2 = pick_operand(anchor);
      it.value_3 = pick_operand(anchor);
      send_item(it);
    end
  endtask

  initial begin
    bfsum_in_t corner[$];
    logic      modes[4];
    sb = new();
    calm = 1'b0;
    hold_req = 1'b0;
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corner items at the reset setting (binary32 accumulation)
    corner.push_back('{16'h0000, 16'h0000, 16'h0000, 16'h0000});
    corner.push_back('{16'h8000, 16'h8000, 16'h8000, 16'h8000});  // negative zeros
    corner.push_back('{16'h0000, 16'h8000, 16'h8000, 16'h8000});
    corner.push_back('{16'hffff, 16'hffff, 16'hffff, 16'hffff});
    corner.push_back('{16'h7f80, 16'hff80, 16'h3f80, 16'h3f80});  // inf minus inf
    corner.push_back('{16'hff80, 16'h7f80, 16'h0000, 16'h0000});
    corner.push_back('{16'h7f80, 16'h3f80, 16'h7f80, 16'h0001});  // infinity kept
    corner.push_back('{16'hff81, 16'h7fc1, 16'h3f80, 16'h0000});  // first nan wins
    corner.push_back('{16'h3f80, 16'h7f81, 16'hffc0, 16'h0000});
    corner.push_back('{16'h3f80, 16'h3f80, 16'h3f80, 16'hff85});
    corner.push_back('{16'h7f7f, 16'h7f7f, 16'h0000, 16'h0000});  // overflow
    corner.push_back('{16'h7f7f, 16'h7b00, 16'h7b00, 16'h0000});  // rounding to inf
    corner.push_back('{16'h0001, 16'h0001, 16'h007f, 16'h8001});  // subnormals
    corner.push_back('{16'h0080, 16'h8001, 16'h0000, 16'h0000});
    corner.push_back('{16'h3f80, 16'hbf80, 16'h0001, 16'h8001});  // exact cancel
    corner.push_back('{16'h3f80, 16'h3380, 16'h3380, 16'h3380});  // ties to even
    corner.push_back('{16'h4b80, 16'h3f80, 16'h3f80, 16'hcb80});
    corner.push_back('{16'h7fff, 16'h0000, 16'h0000, 16'h0000});
    corner.push_back('{16'h0000, 16'h0000, 16'h0000, 16'h7fbf});
    corner.push_back('{16'h5555, 16'haaaa, 16'h5555, 16'haaaa});
    foreach (corner[i]) send_item(corner[i]);
    drain_sums();
    write_rnd_mode(1'b1);
    foreach (corner[i]) send_item(corner[i]);
    drain_sums();

    // random phases over both settings
    modes = '{1'b0, 1'b1, 1'b0, 1'b1};
    foreach (modes[ph]) begin
      write_rnd_mode(modes[ph]);
      if (ph == 3) calm = 1'b1;
      if (ph == 1) begin
        hold_req = 1'b1;  // long receiver stall while items keep coming
        send_random(150);
        drain_sums();     // sender waits out every owed sum
        send_random(150);
      end else begin
        send_random(330);
      end
      drain_sums();
    end

    if (sb.mismatches == 0 && sb.pending_sums.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/bfsum_pkg.sv
design/bfsum_if.sv
design/bfsum_cell.sv
design/bf16_four_way_sum.sv
verif/tb_top.sv
